// File: hdl/absorbing_boundary_field_update_assert.svh
// Assertion macros shared by the boundary update RTL.
`ifndef ABSORBING_BOUNDARY_FIELD_UPDATE_ASSERT_SVH
`define ABSORBING_BOUNDARY_FIELD_UPDATE_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define ABFU_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset.
`define ABFU_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/abfu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package abfu_pkg;

    // Quotient width of the dividers and fraction bits of Q16.16
    localparam int QW        = 32;
    localparam int FRAC      = 16;
    localparam int TW        = 48;
    localparam int CELLS_DEF = 1024;

    localparam logic signed [31:0] MAX32 = 32'sh7fff_ffff;
    localparam logic signed [31:0] MIN32 = 32'sh8000_0000;
    localparam logic signed [48:0] MAX49 = 49'sh0_7fff_ffff;
    localparam logic signed [48:0] MIN49 = -49'sh0_8000_0000;

    // One memory word: prior values of both components
    typedef struct packed {
        logic signed [31:0] a;
        logic signed [31:0] b;
    } t_prior;

    // Q16.16 product scaled back, truncating toward zero
    function automatic logic signed [TW-1:0] trunc_q(input logic signed [63:0] p);
        logic signed [63:0] t;
        t = p + (p[63] ? ((64'sd1 <<< FRAC) - 64'sd1) : 64'sd0);
        return t[63:FRAC];
    endfunction

    // Signed, saturated result from an unsigned quotient and an overflow flag
    function automatic logic signed [31:0] sat_div(input logic [31:0] q,
                                                   input logic ovf,
                                                   input logic neg);
        logic signed [31:0] r;
        if (ovf) begin
            r = neg ? MIN32 : MAX32;
        end else if (neg) begin
            r = (q > 32'h8000_0000) ? MIN32 : -$signed(q);
        end else begin
            r = q[31] ? MAX32 : $signed(q);
        end
        return r;
    endfunction

    // Clamp a 49-bit sum to the signed 32-bit range
    function automatic logic signed [31:0] sat49(input logic signed [48:0] v);
        logic signed [31:0] r;
        if (v > MAX49) begin
            r = MAX32;
        end else if (v < MIN49) begin
            r = MIN32;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hdl/abfu_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Pipelined restoring divider: one quotient bit per stage, QW stages plus an
// input register. Only QW quotient bits are formed; a larger quotient is flagged.
module abfu_div
    import abfu_pkg::*;
#(
    parameter int NW = 48,
    parameter int SW = 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire logic [NW-1:0] i_n,
    input  wire logic [QW-1:0] i_d,
    input  wire logic [SW-1:0] i_sb,
    output logic      [QW-1:0] o_q,
    output logic               o_ovf,
    output logic      [SW-1:0] o_sb
);

    logic [QW-1:0] r_rem [0:QW];
    logic [QW-1:0] r_low [0:QW];
    logic [QW-1:0] r_q   [0:QW];
    logic [QW-1:0] r_d   [0:QW];
    logic          r_ovf [0:QW];
    logic [SW-1:0] r_sb  [0:QW];

    logic [QW-1:0] n_rem [0:QW-1];
    logic [QW-1:0] n_low [0:QW-1];
    logic [QW-1:0] n_q   [0:QW-1];
    logic [QW:0]   w_t   [0:QW-1];
    logic          w_ge  [0:QW-1];

    // one trial subtract per stage
    always_comb begin
        for (int k = 0; k < QW; k++) begin
            w_t[k]   = {r_rem[k], r_low[k][QW-1]};
            w_ge[k]  = (w_t[k] >= {1'b0, r_d[k]});
            n_rem[k] = w_ge[k] ? QW'(w_t[k] - {1'b0, r_d[k]}) : w_t[k][QW-1:0];
            n_low[k] = {r_low[k][QW-2:0], 1'b0};
            n_q[k]   = {r_q[k][QW-2:0], w_ge[k]};
        end
    end

    // stage registers, frozen together when the pipe stalls
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= QW'(i_n[NW-1:QW]);
            r_low[0] <= i_n[QW-1:0];
            r_q[0]   <= '0;
            r_d[0]   <= i_d;
            r_ovf[0] <= (QW'(i_n[NW-1:QW]) >= i_d);
            r_sb[0]  <= i_sb;
            for (int k = 0; k < QW; k++) begin
                r_rem[k+1] <= n_rem[k];
                r_low[k+1] <= n_low[k];
                r_q[k+1]   <= n_q[k];
                r_d[k+1]   <= r_d[k];
                r_ovf[k+1] <= r_ovf[k];
                r_sb[k+1]  <= r_sb[k];
            end
        end
    end

    assign o_q   = r_q[QW];
    assign o_ovf = r_ovf[QW];
    assign o_sb  = r_sb[QW];

endmodule

`default_nettype wire

// File: hdl/abfu_mem.sv
`timescale 1ns / 1ps
`default_nettype none

// Prior-value store, one word per cell, cleared by a sweep after reset.
module abfu_mem
    import abfu_pkg::*;
#(
    parameter int CELLS = CELLS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(CELLS)-1:0] i_rd_addr,
    output t_prior                        o_rd_data,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(CELLS)-1:0] i_wr_addr,
    input  wire t_prior                   i_wr_data,
    output logic                          o_busy
);

    localparam int AW = $clog2(CELLS);

    t_prior          r_mem [0:CELLS-1];
    t_prior          r_rd;
    logic            r_clr_busy;
    logic [AW-1:0]   r_clr_addr;

    // clearing sweep, one entry per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == AW'(CELLS - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // write port: sweep or write-back
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read, held while the pipe stalls
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd;
    assign o_busy    = r_clr_busy;

endmodule

`default_nettype wire

// File: hdl/absorbing_boundary_field_update.sv
// Channel  | valid    | ready    | payload
// ---------+----------+----------+-----------------------------------------------
// request  | i_valid  | o_ready  | i_cell_index, i_inner_*, i_edge_*, i_normal_*,
//          |          |          | i_axis_cell
// result   | o_valid  | i_ready  | o_edge_a_integral, o_edge_b_integral, o_applied
// config   | i_cfg_we | -        | i_cfg_wdata (wave step)
//
// One request per cycle while o_ready is high.
// Two ranks of dividers lie in series (interior fields and vbar, then boundary fields)
// around the read-modify-write of the per-cell store.
// A request for a cell that is still in flight waits until that cell is written back.
// After reset a clearing sweep of all CELLS entries runs with o_ready low.
// The pipe holds only when a result waits at the output and the last stage is full.
`timescale 1ns / 1ps
`default_nettype none
`include "absorbing_boundary_field_update_assert.svh"

module absorbing_boundary_field_update
    import abfu_pkg::*;
#(
    parameter int CELLS = CELLS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic        [30:0] i_cfg_wdata,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic        [9:0]  i_cell_index,
    input  wire logic signed [31:0] i_inner_a_integral,
    input  wire logic signed [31:0] i_inner_b_integral,
    input  wire logic        [30:0] i_inner_a_length,
    input  wire logic        [30:0] i_inner_b_length,
    input  wire logic        [30:0] i_edge_a_length,
    input  wire logic        [30:0] i_edge_b_length,
    input  wire logic        [30:0] i_normal_length,
    input  wire logic               i_axis_cell,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic signed [31:0]      o_edge_a_integral,
    output logic signed [31:0]      o_edge_b_integral,
    output logic                    o_applied
);

    localparam int AW      = $clog2(CELLS);
    localparam int DIV_LAT = QW + 1;
    localparam int P_RANK  = DIV_LAT;
    localparam int M_RANK  = P_RANK + 1;
    localparam int M2_RANK = M_RANK + 1;
    localparam int S1_RANK = M2_RANK + DIV_LAT + 1;
    localparam int S2_RANK = S1_RANK + 1;
    localparam int RANKS   = S2_RANK + 1;
    localparam int RSH     = 20;
    localparam logic [RSH:0] RECIP = (RSH+1)'((1 << RSH) / CELLS);

    // ---------------- configuration ----------------
    logic [30:0] r_wave_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave_step <= '0;
        end else if (i_cfg_we) begin
            r_wave_step <= i_cfg_wdata;
        end
    end

    // ---------------- cell index modulo CELLS ----------------
    logic [30:0]   w_qprod;
    logic [9:0]    w_qt;
    logic [27:0]   w_rem;
    logic [27:0]   w_remf;
    logic [AW-1:0] w_cell;

    always_comb begin
        w_qprod = 31'(i_cell_index) * 31'(RECIP);
        w_qt    = w_qprod[RSH +: 10];
        w_rem   = 28'(i_cell_index) - 28'(w_qt) * 28'(CELLS);
        w_remf  = (w_rem >= 28'(CELLS)) ? (w_rem - 28'(CELLS)) : w_rem;
        w_cell  = w_remf[AW-1:0];
    end

    // ---------------- flow control and cell interlock ----------------
    logic          r_hz_v [0:RANKS-1];
    logic [AW-1:0] r_hz_c [0:RANKS-1];
    logic          r_ovld;
    logic          w_haz;
    logic          w_out_en;
    logic          w_en;
    logic          w_acc;
    logic          w_clr_busy;

    always_comb begin
        w_haz = 1'b0;
        for (int k = 0; k < RANKS; k++) begin
            if (r_hz_v[k] && (r_hz_c[k] == w_cell)) begin
                w_haz = 1'b1;
            end
        end
    end

    assign w_out_en = !r_ovld || i_ready;
    assign w_en     = w_out_en || !r_hz_v[S2_RANK];
    assign o_ready  = w_en && !w_haz && !w_clr_busy;
    assign w_acc    = i_valid && o_ready;

    // valid and cell of every item in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < RANKS; k++) begin
                r_hz_v[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_hz_v[0] <= w_acc;
            for (int k = 1; k < RANKS; k++) begin
                r_hz_v[k] <= r_hz_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_hz_c[0] <= w_cell;
            for (int k = 1; k < RANKS; k++) begin
                r_hz_c[k] <= r_hz_c[k-1];
            end
        end
    end

    // ---------------- front dividers: fields and vbar ----------------
    logic        w_neg_a, w_neg_b;
    logic [31:0] w_mag_a, w_mag_b;
    logic [31:0] w_fq_a, w_fq_b, w_vq;
    logic        w_fo_a, w_fo_b, w_vo;
    logic [1:0]  w_fsb_a, w_fsb_b;
    logic [63:0] w_vsb;

    assign w_neg_a = i_inner_a_integral[31];
    assign w_neg_b = i_inner_b_integral[31];
    assign w_mag_a = w_neg_a ? (32'd0 - i_inner_a_integral) : i_inner_a_integral;
    assign w_mag_b = w_neg_b ? (32'd0 - i_inner_b_integral) : i_inner_b_integral;

    abfu_div #(.NW(48), .SW(2)) u_div_fa (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_n   ({w_mag_a, 16'd0}),
        .i_d   ({1'b0, i_inner_a_length}),
        .i_sb  ({w_neg_a, i_inner_a_length == 31'd0}),
        .o_q   (w_fq_a),
        .o_ovf (w_fo_a),
        .o_sb  (w_fsb_a)
    );

    abfu_div #(.NW(48), .SW(2)) u_div_fb (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_n   ({w_mag_b, 16'd0}),
        .i_d   ({1'b0, i_inner_b_length}),
        .i_sb  ({w_neg_b, (i_inner_b_length == 31'd0) || i_axis_cell}),
        .o_q   (w_fq_b),
        .o_ovf (w_fo_b),
        .o_sb  (w_fsb_b)
    );

    abfu_div #(.NW(48), .SW(64)) u_div_vbar (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_n   ({1'b0, r_wave_step, 16'd0}),
        .i_d   ({1'b0, i_normal_length}),
        .i_sb  ({r_wave_step != 31'd0, i_normal_length == 31'd0,
                 i_edge_a_length, i_edge_b_length}),
        .o_q   (w_vq),
        .o_ovf (w_vo),
        .o_sb  (w_vsb)
    );

    // ---------------- P: saturate fields, form 1-vbar and 1+vbar ----------------
    logic        [30:0] w_vbar;
    logic signed [31:0] r_p_fa, r_p_fb, r_p_omv;
    logic        [31:0] r_p_opv;
    logic               r_p_act;
    logic        [30:0] r_p_ea, r_p_eb;

    assign w_vbar = (w_vsb[62] || w_vo || w_vq[31]) ? 31'h7fff_ffff : w_vq[30:0];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p_fa  <= w_fsb_a[0] ? 32'sd0 : sat_div(w_fq_a, w_fo_a, w_fsb_a[1]);
            r_p_fb  <= w_fsb_b[0] ? 32'sd0 : sat_div(w_fq_b, w_fo_b, w_fsb_b[1]);
            r_p_omv <= 32'sh0001_0000 - $signed({1'b0, w_vbar});
            r_p_opv <= 32'h0001_0000 + {1'b0, w_vbar};
            r_p_act <= w_vsb[63];
            r_p_ea  <= w_vsb[61:31];
            r_p_eb  <= w_vsb[30:0];
        end
    end

    // ---------------- M: interior products ----------------
    logic signed [63:0] r_m_poa, r_m_pta, r_m_pob, r_m_ptb;
    logic signed [31:0] r_m_omv;
    logic        [31:0] r_m_opv;
    logic               r_m_act;
    logic        [30:0] r_m_ea, r_m_eb;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m_poa <= r_p_fa * r_p_omv;
            r_m_pta <= r_p_fa * $signed({1'b0, r_p_opv});
            r_m_pob <= r_p_fb * r_p_omv;
            r_m_ptb <= r_p_fb * $signed({1'b0, r_p_opv});
            r_m_omv <= r_p_omv;
            r_m_opv <= r_p_opv;
            r_m_act <= r_p_act;
            r_m_ea  <= r_p_ea;
            r_m_eb  <= r_p_eb;
        end
    end

    // ---------------- M2: scale back; prior read lands here ----------------
    logic signed [TW-1:0] r_m2_pa, r_m2_ta, r_m2_pb, r_m2_tb;
    logic signed [31:0]   r_m2_omv;
    logic        [31:0]   r_m2_opv;
    logic                 r_m2_act;
    logic        [30:0]   r_m2_ea, r_m2_eb;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m2_pa  <= trunc_q(r_m_poa);
            r_m2_ta  <= trunc_q(r_m_pta);
            r_m2_pb  <= trunc_q(r_m_pob);
            r_m2_tb  <= trunc_q(r_m_ptb);
            r_m2_omv <= r_m_omv;
            r_m2_opv <= r_m_opv;
            r_m2_act <= r_m_act;
            r_m2_ea  <= r_m_ea;
            r_m2_eb  <= r_m_eb;
        end
    end

    // ---------------- prior store ----------------
    t_prior        w_old;
    t_prior        w_wr_data;
    logic          w_rd_en;
    logic          w_wr_en;

    assign w_rd_en = w_en;

    abfu_mem #(.CELLS(CELLS)) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_hz_c[M_RANK]),
        .o_rd_data (w_old),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_hz_c[S2_RANK]),
        .i_wr_data (w_wr_data),
        .o_busy    (w_clr_busy)
    );

    // ---------------- numerator and boundary dividers ----------------
    logic signed [48:0] w_num_a, w_num_b;
    logic [48:0]        w_abs_a, w_abs_b;
    logic [31:0]        w_bq_a, w_bq_b;
    logic               w_bo_a, w_bo_b;
    logic [112:0]       w_bsb_a;
    logic [79:0]        w_bsb_b;

    always_comb begin
        w_num_a = {{17{w_old.a[31]}}, w_old.a} - {r_m2_pa[TW-1], r_m2_pa};
        w_num_b = {{17{w_old.b[31]}}, w_old.b} - {r_m2_pb[TW-1], r_m2_pb};
        w_abs_a = w_num_a[48] ? (49'd0 - w_num_a) : w_num_a;
        w_abs_b = w_num_b[48] ? (49'd0 - w_num_b) : w_num_b;
    end

    abfu_div #(.NW(64), .SW(113)) u_div_ba (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_n   ({w_abs_a[47:0], 16'd0}),
        .i_d   (r_m2_opv),
        .i_sb  ({r_m2_act, r_m2_omv, r_m2_ea, r_m2_ta, w_num_a[48]}),
        .o_q   (w_bq_a),
        .o_ovf (w_bo_a),
        .o_sb  (w_bsb_a)
    );

    abfu_div #(.NW(64), .SW(80)) u_div_bb (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_n   ({w_abs_b[47:0], 16'd0}),
        .i_d   (r_m2_opv),
        .i_sb  ({r_m2_eb, r_m2_tb, w_num_b[48]}),
        .o_q   (w_bq_b),
        .o_ovf (w_bo_b),
        .o_sb  (w_bsb_b)
    );

    // ---------------- S1: saturated boundary fields ----------------
    logic signed [31:0]   r_s1_ba, r_s1_bb, r_s1_omv;
    logic                 r_s1_act;
    logic        [30:0]   r_s1_ea, r_s1_eb;
    logic signed [TW-1:0] r_s1_ta, r_s1_tb;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_ba  <= sat_div(w_bq_a, w_bo_a, w_bsb_a[0]);
            r_s1_bb  <= sat_div(w_bq_b, w_bo_b, w_bsb_b[0]);
            r_s1_act <= w_bsb_a[112];
            r_s1_omv <= w_bsb_a[111:80];
            r_s1_ea  <= w_bsb_a[79:49];
            r_s1_ta  <= w_bsb_a[48:1];
            r_s1_eb  <= w_bsb_b[79:49];
            r_s1_tb  <= w_bsb_b[48:1];
        end
    end

    // ---------------- S2: boundary products ----------------
    logic signed [63:0]   r_s2_poa, r_s2_pea, r_s2_pob, r_s2_peb;
    logic signed [TW-1:0] r_s2_ta, r_s2_tb;
    logic                 r_s2_act;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_poa <= r_s1_ba * r_s1_omv;
            r_s2_pea <= r_s1_ba * $signed({1'b0, r_s1_ea});
            r_s2_pob <= r_s1_bb * r_s1_omv;
            r_s2_peb <= r_s1_bb * $signed({1'b0, r_s1_eb});
            r_s2_ta  <= r_s1_ta;
            r_s2_tb  <= r_s1_tb;
            r_s2_act <= r_s1_act;
        end
    end

    // new prior values and output integrals
    logic signed [TW-1:0] w_tro_a, w_tro_b, w_tre_a, w_tre_b;
    logic signed [48:0]   w_sum_a, w_sum_b;
    logic signed [31:0]   w_out_a, w_out_b;

    always_comb begin
        w_tro_a     = trunc_q(r_s2_poa);
        w_tro_b     = trunc_q(r_s2_pob);
        w_tre_a     = trunc_q(r_s2_pea);
        w_tre_b     = trunc_q(r_s2_peb);
        w_sum_a     = {w_tro_a[TW-1], w_tro_a} + {r_s2_ta[TW-1], r_s2_ta};
        w_sum_b     = {w_tro_b[TW-1], w_tro_b} + {r_s2_tb[TW-1], r_s2_tb};
        w_wr_data.a = sat49(w_sum_a);
        w_wr_data.b = sat49(w_sum_b);
        w_out_a     = sat49({w_tre_a[TW-1], w_tre_a});
        w_out_b     = sat49({w_tre_b[TW-1], w_tre_b});
    end

    assign w_wr_en = w_en && r_hz_v[S2_RANK] && r_s2_act;

    // ---------------- output register ----------------
    logic signed [31:0] r_oa, r_ob;
    logic               r_oapp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (w_out_en) begin
            r_ovld <= r_hz_v[S2_RANK];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_en) begin
            r_oa   <= r_s2_act ? w_out_a : 32'sd0;
            r_ob   <= r_s2_act ? w_out_b : 32'sd0;
            r_oapp <= r_s2_act;
        end
    end

    assign o_valid           = r_ovld;
    assign o_edge_a_integral = r_oa;
    assign o_edge_b_integral = r_ob;
    assign o_applied         = r_oapp;

    // ---------------- checks ----------------
    `ABFU_ASSERT_IMP(a_no_rw_clash, w_rd_en && r_hz_v[M_RANK] && w_wr_en, r_hz_c[M_RANK] != r_hz_c[S2_RANK], "prior read and write-back hit one cell")
    `ABFU_ASSERT_IMP(a_stall_full, !w_en, r_hz_v[S2_RANK] && r_ovld, "pipe held without a waiting result")
    `ABFU_ASSERT_IMP(a_clr_quiet, w_clr_busy, !w_wr_en && !r_hz_v[0], "activity during clearing sweep")
    `ABFU_ASSERT_NXT(a_clr_once, !w_clr_busy, !w_clr_busy, "clearing sweep restarted without reset")

endmodule

`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

    // One boundary-cell request as driven on the input ports
    typedef struct packed {
        logic        [9:0]  idx;
        logic signed [31:0] in_a;
        logic signed [31:0] in_b;
        logic        [30:0] len_a;
        logic        [30:0] len_b;
        logic        [30:0] edge_len_a;
        logic        [30:0] edge_len_b;
        logic        [30:0] normal;
        logic               axis;
    } t_cell_req;

    // Boundary integrals expected back for one request
    typedef struct packed {
        logic signed [31:0] out_a;
        logic signed [31:0] out_b;
        logic               applied;
    } t_edge_res;

    localparam longint Q_ONE = 65536;
    localparam int     WDOG_LIMIT = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [30:0] i_cfg_wdata = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic signed [31:0] o_edge_a_integral;
    logic signed [31:0] o_edge_b_integral;
    logic        o_applied;
    t_cell_req   cur = '0;

    // Stimulus and scoreboard state
    t_cell_req   pending_reqs[$];
    t_edge_res   expected_edges[$];
    int signed   prior_a_mdl[1024];
    int signed   prior_b_mdl[1024];
    logic [30:0] wave_mdl = '0;
    bit          no_gaps = 1'b0;
    bit          stall_kick = 1'b0;
    int          errors = 0;
    int          wdog = 0;

    absorbing_boundary_field_update u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_cell_index       (cur.idx),
        .i_inner_a_integral (cur.in_a),
        .i_inner_b_integral (cur.in_b),
        .i_inner_a_length   (cur.len_a),
        .i_inner_b_length   (cur.len_b),
        .i_edge_a_length    (cur.edge_len_a),
        .i_edge_b_length    (cur.edge_len_b),
        .i_normal_length    (cur.normal),
        .i_axis_cell        (cur.axis),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_edge_a_integral  (o_edge_a_integral),
        .o_edge_b_integral  (o_edge_b_integral),
        .o_applied          (o_applied)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Signed 32-bit clamp
    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Interior field from a line integral; zero length gives zero field
    function automatic longint inner_field(input longint integ, input longint len);
        if (len == 0) return 0;
        return clamp32((integ * Q_ONE) / len);
    endfunction

    // Mur update of one component: output integral and new prior value
    task automatic mur_component(input longint old, input longint inner,
                                 input longint vbar, input longint edge_len,
                                 output longint integ, output longint nxt);
        longint omv, opv, num, bnd;
        omv = Q_ONE - vbar;
        opv = Q_ONE + vbar;
        num = old - (inner * omv) / Q_ONE;
        bnd = clamp32((num * Q_ONE) / opv);
        nxt = clamp32((bnd * omv) / Q_ONE + (inner * opv) / Q_ONE);
        integ = clamp32((bnd * edge_len) / Q_ONE);
    endtask

    // Predict the result of one request and advance the per-cell priors
    task automatic predict_edge(input t_cell_req r, output t_edge_res res);
        longint ia, ib, vbar, oa, ob, na, nb, q;
        res = '0;
        if (wave_mdl == 0) return;
        ia = inner_field(longint'(r.in_a), longint'(r.len_a));
        ib = r.axis ? 0 : inner_field(longint'(r.in_b), longint'(r.len_b));
        if (r.normal == 0) begin
            vbar = 64'h7fff_ffff;
        end else begin
            q = (longint'(wave_mdl) * Q_ONE) / longint'(r.normal);
            vbar = (q > 64'h7fff_ffff) ? 64'h7fff_ffff : q;
        end
        mur_component(longint'(prior_a_mdl[r.idx]), ia, vbar, longint'(r.edge_len_a), oa, na);
        mur_component(longint'(prior_b_mdl[r.idx]), ib, vbar, longint'(r.edge_len_b), ob, nb);
        prior_a_mdl[r.idx] = int'(na);
        prior_b_mdl[r.idx] = int'(nb);
        res.out_a = oa[31:0];
        res.out_b = ob[31:0];
        res.applied = 1'b1;
    endtask

    // Realistic request: lengths near one cell, moderate fields, few cells reused
    function automatic t_cell_req rand_req();
        t_cell_req r;
        r.idx        = ($urandom_range(3) == 0) ? 10'($urandom) : 10'($urandom_range(15));
        r.in_a       = ($urandom_range(9) == 0) ? $urandom : $signed(32'($urandom_range(
                       32'h0040_0000))) - 32'sh0020_0000;
        r.in_b       = ($urandom_range(9) == 0) ? $urandom : $signed(32'($urandom_range(
                       32'h0040_0000))) - 32'sh0020_0000;
        r.len_a      = ($urandom_range(9) == 0) ? 31'($urandom) : 31'($urandom_range(
                       32'h0002_0000, 32'h0000_4000));
        r.len_b      = ($urandom_range(9) == 0) ? 31'($urandom) : 31'($urandom_range(
                       32'h0002_0000, 32'h0000_4000));
        r.edge_len_a = ($urandom_range(9) == 0) ? 31'($urandom) : 31'($urandom_range(
                       32'h0002_0000, 32'h0000_4000));
        r.edge_len_b = ($urandom_range(9) == 0) ? 31'($urandom) : 31'($urandom_range(
                       32'h0002_0000, 32'h0000_4000));
        r.normal     = ($urandom_range(9) == 0) ? 31'($urandom) : 31'($urandom_range(
                       32'h0004_0000, 32'h0000_2000));
        r.axis       = ($urandom_range(7) == 0);
        return r;
    endfunction

    // Directed request built from explicit values
    function automatic t_cell_req mk_req(input logic [9:0] c, input logic [31:0] a,
                                         input logic [31:0] b, input logic [30:0] la,
                                         input logic [30:0] lb, input logic [30:0] ea,
                                         input logic [30:0] eb, input logic [30:0] n,
                                         input logic ax);
        t_cell_req r;
        r = '{c, a, b, la, lb, ea, eb, n, ax};
        return r;
    endfunction

    // Request driver: holds a request until taken, random gaps otherwise
    always @(posedge i_clk) begin
        bit        take;
        t_edge_res res;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            take = i_valid && o_ready;
            if (take) begin
                predict_edge(pending_reqs[0], res);
                expected_edges.push_back(res);
                void'(pending_reqs.pop_front());
            end
            if (i_valid && !take) begin
                // hold current request
            end else if (pending_reqs.size() > 0 &&
                         (no_gaps || $urandom_range(99) >= 20)) begin
                cur     <= pending_reqs[0];
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Result monitor and receiver back-pressure
    always @(posedge i_clk) begin
        int        hold_cnt;
        t_edge_res e;
        if (!i_rst_n) begin
            i_ready  <= 1'b0;
            hold_cnt = 0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_edges.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result a=%0d b=%0d applied=%0b", $time,
                             o_edge_a_integral, o_edge_b_integral, o_applied);
                end else begin
                    e = expected_edges.pop_front();
                    if (o_edge_a_integral !== e.out_a) begin
                        errors++;
                        $display("%0t: edge_a_integral expected %0d actual %0d", $time,
                                 e.out_a, o_edge_a_integral);
                    end
                    if (o_edge_b_integral !== e.out_b) begin
                        errors++;
                        $display("%0t: edge_b_integral expected %0d actual %0d", $time,
                                 e.out_b, o_edge_b_integral);
                    end
                    if (o_applied !== e.applied) begin
                        errors++;
                        $display("%0t: applied expected %0b actual %0b", $time,
                                 e.applied, o_applied);
                    end
                end
            end
            if (stall_kick) begin
                stall_kick = 1'b0;
                hold_cnt = 400;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= no_gaps || ($urandom_range(99) >= 20);
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            wdog <= 0;
        end else if (wdog >= WDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            wdog <= wdog + 1;
        end
    end

    // Write the wave step while the block is drained
    task automatic set_wave(input logic [30:0] w);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= w;
        wave_mdl = w;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        wait (pending_reqs.size() == 0 && expected_edges.size() == 0);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic random_phase(input logic [30:0] w, input int n);
        set_wave(w);
        repeat (n) pending_reqs.push_back(rand_req());
        drain();
    endtask

    initial begin
        for (int i = 0; i < 1024; i++) begin
            prior_a_mdl[i] = 0;
            prior_b_mdl[i] = 0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wave step still zero after reset: nothing is applied
        pending_reqs.push_back(mk_req(10'd5, 32'h0001_0000, 32'h8000_0000, 31'h1_0000,
                               31'h1_0000, 31'h1_0000, 31'h1_0000, 31'h1_0000, 1'b0));
        pending_reqs.push_back(rand_req());
        drain();

        // Directed corners at wave step of one
        set_wave(31'h0001_0000);
        pending_reqs.push_back(mk_req(10'd0, 32'h0001_0000, 32'h0002_0000, 31'h1_0000,
                               31'h1_0000, 31'h1_0000, 31'h1_0000, 31'h1_0000, 1'b0));
        pending_reqs.push_back(mk_req(10'd0, 32'h0001_0000, 32'h0002_0000, 31'h1_0000,
                               31'h1_0000, 31'h1_0000, 31'h1_0000, 31'h1_0000, 1'b0));
        pending_reqs.push_back(mk_req(10'd1023, 32'h7fff_ffff, 32'h8000_0000, 31'h7fff_ffff,
                               31'h7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff,
                               31'h7fff_ffff, 1'b0));
        pending_reqs.push_back(mk_req(10'd1023, 32'h7fff_ffff, 32'h8000_0000, 31'd1, 31'd1,
                               31'h7fff_ffff, 31'h7fff_ffff, 31'd1, 1'b0));
        pending_reqs.push_back(mk_req(10'd1022, 32'h8000_0000, 32'h7fff_ffff, 31'd1, 31'd1,
                               31'd1, 31'd1, 31'h1_0000, 1'b0));
        // zero inner lengths
        pending_reqs.push_back(mk_req(10'd2, 32'h0005_0000, 32'hfffb_0000, 31'd0, 31'd0,
                               31'h1_0000, 31'h1_0000, 31'h1_0000, 1'b0));
        // zero normal length
        pending_reqs.push_back(mk_req(10'd3, 32'h0005_0000, 32'hfffb_0000, 31'h1_0000,
                               31'h1_0000, 31'h1_0000, 31'h1_0000, 31'd0, 1'b0));
        // zero edge lengths
        pending_reqs.push_back(mk_req(10'd4, 32'h0005_0000, 32'hfffb_0000, 31'h1_0000,
                               31'h1_0000, 31'd0, 31'd0, 31'h1_0000, 1'b0));
        // axis cell, then same cell without axis
        pending_reqs.push_back(mk_req(10'd6, 32'h0003_0000, 32'h7fff_ffff, 31'h1_0000,
                               31'h1_0000, 31'h1_0000, 31'h1_0000, 31'h2_0000, 1'b1));
        pending_reqs.push_back(mk_req(10'd6, 32'h0003_0000, 32'h7fff_ffff, 31'h1_0000,
                               31'h1_0000, 31'h1_0000, 31'h1_0000, 31'h2_0000, 1'b0));
        pending_reqs.push_back(mk_req(10'd7, 32'h0000_0000, 32'hffff_ffff, 31'h5555_5555,
                               31'h2aaa_aaaa, 31'h5555_5555, 31'h2aaa_aaaa,
                               31'h5555_5555, 1'b1));
        pending_reqs.push_back(mk_req(10'd512, 32'h5555_5555, 32'haaaa_aaaa, 31'h2aaa_aaaa,
                               31'h5555_5555, 31'h2aaa_aaaa, 31'h5555_5555,
                               31'h2aaa_aaaa, 1'b0));
        drain();

        // Random phases over several wave steps, extremes included
        random_phase(31'h0000_8000, 90);
        no_gaps = 1'b1;
        random_phase(31'h0001_0000, 90);
        no_gaps = 1'b0;
        random_phase(31'h7fff_ffff, 80);
        // long receiver hold-off while requests keep coming
        set_wave(31'd1);
        stall_kick = 1'b1;
        repeat (100) pending_reqs.push_back(rand_req());
        drain();
        random_phase(31'($urandom_range(32'h0004_0000)), 80);
        random_phase(31'h0000_0000, 20);
        random_phase(31'($urandom), 70);

        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+hdl
hdl/abfu_pkg.sv
hdl/abfu_div.sv
hdl/abfu_mem.sv
hdl/absorbing_boundary_field_update.sv
tb/testbench.sv
